// File: src/gbn_pkg.sv
`default_nettype none
package gbn_pkg;

  localparam int COORD_W = 20;
  localparam int SCORE_W = 16;
  localparam int AREA_W  = 2 * COORD_W;
  localparam logic [SCORE_W-1:0] THR_RESET = 16'd32768;

  typedef struct packed {
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [SCORE_W-1:0] score;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  typedef enum logic [3:0] {
    STEP_IDLE,
    STEP_INIT,
    STEP_READ,
    STEP_SPAN,
    STEP_INTER,
    STEP_AREA,
    STEP_UNION,
    STEP_MUL_LO,
    STEP_MUL_HI,
    STEP_DECIDE,
    STEP_NEXT,
    STEP_ROUND_END
  } step_t;

  typedef struct packed {
    logic  store;
    step_t step;
  } cmd_t;

  typedef struct packed {
    logic entry_done;
    logic idx_last;
    logic best_valid;
  } stat_t;

endpackage
`default_nettype wire

// File: src/gbn_ram.sv
`default_nettype none
module gbn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: src/gbn_ctrl.sv
`default_nettype none
module gbn_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic          final_box,
  input  wire gbn_pkg::stat_t stat,
  output logic               busy,
  output gbn_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_READ, S_SPAN, S_INTER, S_AREA, S_UNION,
    S_MLO, S_MHI, S_DECIDE, S_NEXT, S_REND
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (start && final_box) state_nxt = S_INIT;
      S_INIT:   state_nxt = S_READ;
      // entries already kept or suppressed skip the overlap math
      S_READ:   state_nxt = stat.entry_done ? S_NEXT : S_SPAN;
      S_SPAN:   state_nxt = S_INTER;
      S_INTER:  state_nxt = S_AREA;
      S_AREA:   state_nxt = S_UNION;
      S_UNION:  state_nxt = S_MLO;
      S_MLO:    state_nxt = S_MHI;
      S_MHI:    state_nxt = S_DECIDE;
      S_DECIDE: state_nxt = S_NEXT;
      S_NEXT:   state_nxt = stat.idx_last ? S_REND : S_READ;
      S_REND:   state_nxt = stat.best_valid ? S_INIT : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    cmd.store = start && (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE:   cmd.step = gbn_pkg::STEP_IDLE;
      S_INIT:   cmd.step = gbn_pkg::STEP_INIT;
      S_READ:   cmd.step = gbn_pkg::STEP_READ;
      S_SPAN:   cmd.step = gbn_pkg::STEP_SPAN;
      S_INTER:  cmd.step = gbn_pkg::STEP_INTER;
      S_AREA:   cmd.step = gbn_pkg::STEP_AREA;
      S_UNION:  cmd.step = gbn_pkg::STEP_UNION;
      S_MLO:    cmd.step = gbn_pkg::STEP_MUL_LO;
      S_MHI:    cmd.step = gbn_pkg::STEP_MUL_HI;
      S_DECIDE: cmd.step = gbn_pkg::STEP_DECIDE;
      S_NEXT:   cmd.step = gbn_pkg::STEP_NEXT;
      S_REND:   cmd.step = gbn_pkg::STEP_ROUND_END;
      default:  cmd.step = gbn_pkg::STEP_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: src/gbn_dpath.sv
`default_nettype none
module gbn_dpath #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire gbn_pkg::cmd_t                cmd,
  output gbn_pkg::stat_t                    stat,
  input  wire logic                         cfg_we,
  input  wire logic [gbn_pkg::SCORE_W-1:0]  cfg_wdata,
  input  wire gbn_pkg::box_t                in_box,
  output logic                              out_valid,
  output gbn_pkg::box_t                     out_box,
  output logic                              out_last,
  output logic                              out_ovf
);

  localparam int IW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int CWD = gbn_pkg::COORD_W;
  localparam int AW = gbn_pkg::AREA_W;
  localparam int UW = AW + 1;
  localparam int LOW = 21;
  localparam int SW = gbn_pkg::SCORE_W;
  localparam int CMPW = UW + SW;

  function automatic logic [CWD-1:0] span(input logic [CWD-1:0] lo,
                                          input logic [CWD-1:0] hi);
    return (hi > lo) ? hi - lo : '0;
  endfunction

  logic [SW-1:0]      thr_r;
  logic [CW-1:0]      count_r;
  logic               ovf_r;
  logic [MAX_BOXES-1:0] done_r;
  logic [IW-1:0]      idx_r;
  logic [CWD-1:0]     iw_r, ih_r, ws_r, hs_r;
  logic [AW-1:0]      inter_r, areab_r, best_area_r, kept_area_r;
  logic [UW-1:0]      uni_r;
  logic [LOW+SW-1:0]  plo_r;
  logic [UW-LOW+SW-1:0] phi_r;
  logic               best_valid_r, have_kept_r;
  logic [IW-1:0]      best_idx_r;
  gbn_pkg::box_t      best_r, kept_r, rd_box, out_box_r;
  logic               out_valid_r, out_last_r, out_ovf_r;
  logic [gbn_pkg::BOX_W-1:0] rdata;
  logic               room, ram_we, supp;
  logic [CMPW-1:0]    lhs, rhs;

  assign room   = (count_r < CW'(MAX_BOXES));
  assign ram_we = cmd.store && room;

  gbn_ram #(.WIDTH(gbn_pkg::BOX_W), .DEPTH(MAX_BOXES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[IW-1:0]),
    .wdata (in_box),
    .raddr (idx_r),
    .rdata (rdata)
  );

  assign rd_box = gbn_pkg::box_t'(rdata);

  // inter * 65536 > thr * union, the product split into low and high partial products
  assign lhs  = CMPW'({inter_r, 16'd0});
  assign rhs  = CMPW'({phi_r, {LOW{1'b0}}}) + CMPW'(plo_r);
  assign supp = have_kept_r && (iw_r != '0) && (ih_r != '0) && (lhs > rhs);

  assign stat.entry_done = done_r[idx_r];
  assign stat.idx_last   = ((CW'(idx_r) + CW'(1)) == count_r);
  assign stat.best_valid = best_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r        <= gbn_pkg::THR_RESET;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      done_r       <= '0;
      best_valid_r <= 1'b0;
      have_kept_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (cmd.store) begin
        if (room) begin
          count_r <= count_r + CW'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      unique case (cmd.step)
        gbn_pkg::STEP_INIT: begin
          best_valid_r <= 1'b0;
        end
        gbn_pkg::STEP_DECIDE: begin
          if (supp) begin
            done_r[idx_r] <= 1'b1;
          end else if (!best_valid_r || rd_box.score > best_r.score) begin
            best_valid_r <= 1'b1;
          end
        end
        gbn_pkg::STEP_ROUND_END: begin
          if (have_kept_r) begin
            out_valid_r <= 1'b1;
          end
          if (best_valid_r) begin
            have_kept_r        <= 1'b1;
            done_r[best_idx_r] <= 1'b1;
          end else begin
            have_kept_r <= 1'b0;
            count_r     <= '0;
            ovf_r       <= 1'b0;
            done_r      <= '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (cmd.step)
      gbn_pkg::STEP_INIT: idx_r <= '0;
      gbn_pkg::STEP_SPAN: begin
        iw_r <= span((kept_r.left > rd_box.left) ? kept_r.left : rd_box.left,
                     (kept_r.right < rd_box.right) ? kept_r.right : rd_box.right);
        ih_r <= span((kept_r.top > rd_box.top) ? kept_r.top : rd_box.top,
                     (kept_r.bottom < rd_box.bottom) ? kept_r.bottom : rd_box.bottom);
        ws_r <= span(rd_box.left, rd_box.right);
        hs_r <= span(rd_box.top, rd_box.bottom);
      end
      gbn_pkg::STEP_INTER:  inter_r <= iw_r * ih_r;
      gbn_pkg::STEP_AREA:   areab_r <= ws_r * hs_r;
      gbn_pkg::STEP_UNION:  uni_r <= UW'(kept_area_r) + UW'(areab_r) - UW'(inter_r);
      gbn_pkg::STEP_MUL_LO: plo_r <= uni_r[LOW-1:0] * thr_r;
      gbn_pkg::STEP_MUL_HI: phi_r <= uni_r[UW-1:LOW] * thr_r;
      gbn_pkg::STEP_DECIDE: begin
        if (!supp && (!best_valid_r || rd_box.score > best_r.score)) begin
          best_r      <= rd_box;
          best_idx_r  <= idx_r;
          best_area_r <= areab_r;
        end
      end
      gbn_pkg::STEP_NEXT: begin
        if (!stat.idx_last) begin
          idx_r <= idx_r + IW'(1);
        end
      end
      gbn_pkg::STEP_ROUND_END: begin
        out_box_r  <= kept_r;
        out_last_r <= !best_valid_r;
        out_ovf_r  <= ovf_r;
        if (best_valid_r) begin
          kept_r      <= best_r;
          kept_area_r <= best_area_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_box   = out_box_r;
  assign out_last  = out_last_r;
  assign out_ovf   = out_ovf_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_BOXES)) else $error("box count past capacity");

  a_beat_after_round: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.step == gbn_pkg::STEP_ROUND_END))
    else $error("result beat outside a round end");

  a_supp_needs_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == gbn_pkg::STEP_DECIDE && supp) |-> have_kept_r)
    else $error("suppression with no kept box");

  a_set_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == gbn_pkg::STEP_ROUND_END && !best_valid_r) |=>
      (count_r == '0 && done_r == '0 && !have_kept_r))
    else $error("set state not cleared");

endmodule
`default_nettype wire

// File: src/greedy_box_nms.sv
// load: one box per cycle while not busy; busy stays low until the final box is taken
// resolve: (K+1) passes over the n stored boxes, K kept boxes, one box store read port;
//   a live entry takes every step, a done one read and next; passes add init and round end
// results: one beat per kept box in score order, one cycle wide, no back pressure
// reset: synchronous active low; clears the count, masks, handshake and sets threshold 0.5
`default_nettype none
module greedy_box_nms #(
  parameter int MAX_BOXES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [19:0] in_left,
  input  wire logic [19:0] in_top,
  input  wire logic [19:0] in_right,
  input  wire logic [19:0] in_bottom,
  input  wire logic [15:0] in_score,
  input  wire logic        in_final_box,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  output logic             out_valid,
  output logic [19:0]      out_kept_left,
  output logic [19:0]      out_kept_top,
  output logic [19:0]      out_kept_right,
  output logic [19:0]      out_kept_bottom,
  output logic [15:0]      out_kept_score,
  output logic             out_last_kept,
  output logic             out_overflowed
);

  gbn_pkg::cmd_t  cmd;
  gbn_pkg::stat_t stat;
  gbn_pkg::box_t  in_box, out_box;

  assign in_box.left   = in_left;
  assign in_box.top    = in_top;
  assign in_box.right  = in_right;
  assign in_box.bottom = in_bottom;
  assign in_box.score  = in_score;

  gbn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .final_box (in_final_box),
    .stat      (stat),
    .busy      (busy),
    .cmd       (cmd)
  );

  gbn_dpath #(.MAX_BOXES(MAX_BOXES)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_box    (in_box),
    .out_valid (out_valid),
    .out_box   (out_box),
    .out_last  (out_last_kept),
    .out_ovf   (out_overflowed)
  );

  assign out_kept_left   = out_box.left;
  assign out_kept_top    = out_box.top;
  assign out_kept_right  = out_box.right;
  assign out_kept_bottom = out_box.bottom;
  assign out_kept_score  = out_box.score;

endmodule
`default_nettype wire
